FILE: hdl/nearest_palette_color_core_macros.svh
// Assertion macros for the nearest palette color core.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef NEAREST_PALETTE_COLOR_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk and quiet during reset.
`define NPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NPC_ASSERT_IMPL(label, ante, cons, msg)
`define NPC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/npc_pkg.sv
// Shared widths, codes and types of the nearest palette color core.
// No dependencies; the core top level imports it and npc_if uses its widths.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

    // Palette size and the widths that follow from it.
    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int SCAN_W        = $clog2(PALETTE_DEPTH + 1);

    // Fixed field widths.
    localparam int COLOR_W       = 8;
    localparam int ENTRY_W       = 3 * COLOR_W;
    localparam int INDEX_W       = 8;
    localparam int PCOUNT_W      = 9;
    localparam int WEIGHT_W      = 8;
    localparam int SQ_W          = 2 * COLOR_W;
    localparam int PROD_W        = SQ_W + WEIGHT_W;
    localparam int DIST_W        = 26;
    localparam int MATCH_IDX_W   = 8;

    // Configuration port.
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = PCOUNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT   = 2'd3;

    // Input word operation codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Color channel walked by the distance sequencer.
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

endpackage

`default_nettype wire

FILE: hdl/npc_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on npc_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: palette writes and color queries.
interface npc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [npc_pkg::INDEX_W-1:0] entry_index;
    logic [npc_pkg::COLOR_W-1:0] red;
    logic [npc_pkg::COLOR_W-1:0] green;
    logic [npc_pkg::COLOR_W-1:0] blue;

    modport source (output valid, func, entry_index, red, green, blue, input ready);
    modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

// Result channel: one word per query.
interface npc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [npc_pkg::MATCH_IDX_W-1:0] match_index;
    logic                            match_found;
    logic [npc_pkg::DIST_W-1:0]      match_distance;

    modport source (output valid, match_index, match_found, match_distance, input ready);
    modport sink   (input valid, match_index, match_found, match_distance, output ready);
endinterface

`default_nettype wire

FILE: hdl/npc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the palette entries of the core.
`timescale 1ns / 1ps
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nearest_palette_color_core.sv
// Weighted nearest palette color search: top level with sequencer and shared multiplier.
// Depends on npc_pkg, npc_if, npc_ram and nearest_palette_color_core_macros.svh.
//
// Usage:
//   req carries words of two kinds. A write word (func = 0) stores red, green and blue
//   in palette slot entry_index and gives no result; slots at or beyond
//   the palette depth are ignored. A query word (func = 1) scans entries 0 to
//   palette_count - 1, capped at the palette depth, and returns one word on rsp
//   with the index, a found flag and the weighted squared distance of the nearest
//   entry (lowest index on ties). A query stops early at an exact match. An empty
//   palette gives found = 0. Every queried entry must have been written since reset.
// Datapath:
//   One 16x8 multiplier is shared for the squares and the weight products, so each
//   scanned entry takes a memory read, three square and three weight passes, and a
//   compare in turn. req is not ready while a query runs.
// Reset and stalls:
//   Reset clears the palette count to zero and every weight to one; the palette
//   contents stay undefined until written. One result word waits in the output
//   register while rsp stalls, and the next query may run meanwhile; it holds in
//   its last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_core_macros.svh"

module nearest_palette_color_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    npc_req_if.sink                             req,
    npc_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [npc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [npc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import npc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_WGT  = 6'b001000,
        ST_CMP  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    // Control state.
    state_t                state_reg,     state_next;
    logic [SCAN_W-1:0]     n_reg,         n_next;
    logic [SCAN_W-1:0]     k_reg,         k_next;
    chan_t                 ch_reg,        ch_next;
    logic                  found_reg,     found_next;
    logic                  out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [PCOUNT_W-1:0]   count_reg;
    logic [WEIGHT_W-1:0]   red_weight_reg;
    logic [WEIGHT_W-1:0]   green_weight_reg;
    logic [WEIGHT_W-1:0]   blue_weight_reg;

    // Datapath registers.
    logic [COLOR_W-1:0]    q_red_reg,     q_red_next;
    logic [COLOR_W-1:0]    q_green_reg,   q_green_next;
    logic [COLOR_W-1:0]    q_blue_reg,    q_blue_next;
    logic [SQ_W-1:0]       sq_reg,        sq_next;
    logic [DIST_W-1:0]     acc_reg,       acc_next;
    logic [DIST_W-1:0]     best_dst_reg,  best_dst_next;
    logic [ADDR_W-1:0]     best_idx_reg,  best_idx_next;
    logic [MATCH_IDX_W-1:0] out_idx_reg,  out_idx_next;
    logic                  out_found_reg, out_found_next;
    logic [DIST_W-1:0]     out_dst_reg,   out_dst_next;

    // Combinational helpers.
    logic                  req_fire;
    logic [31:0]           wr_idx_ext;
    logic [31:0]           cnt_ext;
    logic [31:0]           best_idx_ext;
    logic [SCAN_W-1:0]     sat_n;
    logic [SCAN_W-1:0]     k_inc;
    logic                  ram_we;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [COLOR_W-1:0]    pal_c;
    logic [COLOR_W-1:0]    qry_c;
    logic [WEIGHT_W-1:0]   weight_c;
    logic [COLOR_W-1:0]    diff;
    logic [SQ_W-1:0]       mult_a;
    logic [WEIGHT_W-1:0]   mult_b;
    logic [PROD_W-1:0]     prod;
    logic                  better;

    // Handshake and index conditioning.
    assign req.ready    = (state_reg == ST_IDLE);
    assign req_fire     = req.valid && req.ready;
    assign wr_idx_ext   = 32'(req.entry_index);
    assign cnt_ext      = 32'(count_reg);
    assign best_idx_ext = 32'(best_idx_reg);
    assign sat_n        = (cnt_ext > 32'(PALETTE_DEPTH)) ? SCAN_W'(PALETTE_DEPTH)
                                                          : SCAN_W'(cnt_ext);
    assign k_inc        = k_reg + SCAN_W'(1);
    assign ram_we       = req_fire && (req.func == FUNC_WRITE)
                          && (wr_idx_ext < 32'(PALETTE_DEPTH));
    assign ram_re       = (state_reg == ST_READ);

    // Palette memory.
    npc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_ext[ADDR_W-1:0]),
        .wdata ({req.red, req.green, req.blue}),
        .re    (ram_re),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Channel selection for the shared multiplier.
    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                pal_c    = ram_rdata[3*COLOR_W-1:2*COLOR_W];
                qry_c    = q_red_reg;
                weight_c = red_weight_reg;
            end
            CH_GREEN:
            begin
                pal_c    = ram_rdata[2*COLOR_W-1:COLOR_W];
                qry_c    = q_green_reg;
                weight_c = green_weight_reg;
            end
            CH_BLUE:
            begin
                pal_c    = ram_rdata[COLOR_W-1:0];
                qry_c    = q_blue_reg;
                weight_c = blue_weight_reg;
            end
            default:
            begin
                pal_c    = '0;
                qry_c    = '0;
                weight_c = '0;
            end
        endcase
    end

    // Shared multiplier: squares the channel difference, then applies the weight.
    assign diff   = (pal_c >= qry_c) ? (pal_c - qry_c) : (qry_c - pal_c);
    assign mult_a = (state_reg == ST_WGT) ? sq_reg   : SQ_W'(diff);
    assign mult_b = (state_reg == ST_WGT) ? weight_c : diff;
    assign prod   = PROD_W'(mult_a) * PROD_W'(mult_b);
    assign better = !found_reg || (acc_reg < best_dst_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        ch_next        = ch_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        q_red_next     = q_red_reg;
        q_green_next   = q_green_reg;
        q_blue_next    = q_blue_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        best_dst_next  = best_dst_reg;
        best_idx_next  = best_idx_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_dst_next   = out_dst_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.func == FUNC_QUERY))
                begin
                    q_red_next    = req.red;
                    q_green_next  = req.green;
                    q_blue_next   = req.blue;
                    n_next        = sat_n;
                    k_next        = '0;
                    found_next    = 1'b0;
                    best_dst_next = '0;
                    best_idx_next = '0;
                    state_next    = (sat_n == '0) ? ST_EMIT : ST_READ;
                end
            end
            ST_READ:
            begin
                ch_next    = CH_RED;
                acc_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sq_next    = prod[SQ_W-1:0];
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                acc_next = acc_reg + DIST_W'(prod);
                case (ch_reg)
                    CH_RED:
                    begin
                        ch_next    = CH_GREEN;
                        state_next = ST_SQ;
                    end
                    CH_GREEN:
                    begin
                        ch_next    = CH_BLUE;
                        state_next = ST_SQ;
                    end
                    default:
                    begin
                        state_next = ST_CMP;
                    end
                endcase
            end
            ST_CMP:
            begin
                if (better)
                begin
                    found_next    = 1'b1;
                    best_dst_next = acc_reg;
                    best_idx_next = k_reg[ADDR_W-1:0];
                end
                // An exact match cannot be beaten by a later entry.
                if ((acc_reg == '0) || (k_inc == n_reg))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_idx_next   = best_idx_ext[MATCH_IDX_W-1:0];
                    out_found_next = found_reg;
                    out_dst_next   = best_dst_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            k_reg         <= '0;
            ch_reg        <= CH_RED;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            ch_reg        <= ch_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            red_weight_reg   <= WEIGHT_W'(1);
            green_weight_reg <= WEIGHT_W'(1);
            blue_weight_reg  <= WEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PALETTE_COUNT: count_reg        <= cfg_data[PCOUNT_W-1:0];
                REG_RED_WEIGHT:    red_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT:  green_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:   blue_weight_reg  <= cfg_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_red_reg     <= q_red_next;
        q_green_reg   <= q_green_next;
        q_blue_reg    <= q_blue_next;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        best_dst_reg  <= best_dst_next;
        best_idx_reg  <= best_idx_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
        out_dst_reg   <= out_dst_next;
    end

    // Result channel.
    assign rsp.valid          = out_valid_reg;
    assign rsp.match_index    = out_idx_reg;
    assign rsp.match_found    = out_found_reg;
    assign rsp.match_distance = out_dst_reg;

    // The scan pointer stays inside the saturated count while an entry is in work.
    `NPC_ASSERT_IMPL(a_scan_in_range, state_reg == ST_READ || state_reg == ST_SQ || state_reg == ST_WGT || state_reg == ST_CMP, k_reg < n_reg, "scan index beyond palette count")

    // An accepted query makes the block busy in the next cycle.
    `NPC_ASSERT_NEXT(a_busy_after_query, req.valid && req.ready && req.func == FUNC_QUERY, !req.ready, "request accepted during a query")

    // An empty search reports index and distance as zero.
    `NPC_ASSERT_IMPL(a_empty_result, rsp.valid && !rsp.match_found, rsp.match_index == '0 && rsp.match_distance == '0, "empty search with nonzero payload")

    // The best distance never grows during a scan.
    `NPC_ASSERT_IMPL(a_best_monotonic, found_reg && $past(found_reg) && $past(state_reg) != ST_IDLE, best_dst_reg <= $past(best_dst_reg), "best distance increased")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for nearest_palette_color_core: fills the palette, runs searches and checks results.
// Depends on npc_pkg, npc_if and the core RTL. It keeps its own palette copy to predict results.
`timescale 1ns / 1ps

module tb_top;
    import npc_pkg::*;

    // Cycles without any accepted word or register write before the run is declared hung.
    localparam int STALL_LIMIT  = 10000;
    // Quiet cycles let pass after the last result of a phase.
    localparam int DRAIN_CYCLES = 20;
    // Least number of words sent by the random search test; its last phase may run past it.
    localparam int RANDOM_WORDS = 330;

    typedef struct packed {
        logic [MATCH_IDX_W-1:0] index;
        logic                   found;
        logic [DIST_W-1:0]      distance;
    } palette_match_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    npc_req_if req_bus ();
    npc_rsp_if rsp_bus ();

    nearest_palette_color_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the palette and the registers.
    logic [ENTRY_W-1:0]  palette_model [PALETTE_DEPTH];
    logic [PCOUNT_W-1:0] count_model;
    logic [WEIGHT_W-1:0] weight_model [3];

    palette_match_t pending_matches [$];
    palette_match_t expected_match;
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    bit             quiet_mode     = 1'b0;
    int             rsp_stall_pct  = 10;
    int             stall_window   = 64;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Squared difference of one color channel.
    function automatic int unsigned channel_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
        int unsigned d;
        d = (a >= b) ? a - b : b - a;
        return d * d;
    endfunction

    // Nearest entry over the searched part of the palette, lowest index on ties.
    function automatic palette_match_t nearest_entry(logic [ENTRY_W-1:0] color);
        palette_match_t  m;
        int unsigned     n;
        int unsigned     cand_dst;
        int unsigned     best;
        logic [ENTRY_W-1:0] e;
        m    = '0;
        best = 0;
        n    = (count_model > PALETTE_DEPTH) ? PALETTE_DEPTH : count_model;
        for (int unsigned k = 0; k < n; k++)
        begin
            e        = palette_model[k];
            cand_dst = channel_sq(color[23:16], e[23:16]) * weight_model[CH_RED]
                     + channel_sq(color[15:8],  e[15:8])  * weight_model[CH_GREEN]
                     + channel_sq(color[7:0],   e[7:0])   * weight_model[CH_BLUE];
            if (!m.found || cand_dst < best)
            begin
                m.found = 1'b1;
                m.index = MATCH_IDX_W'(k);
                best    = cand_dst;
            end
            // An exact match cannot be beaten, so the search stops here.
            if (cand_dst == 0)
                break;
        end
        m.distance = best[DIST_W-1:0];
        return m;
    endfunction

    // Weights lean toward the extremes.
    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // One register write; the block must be idle.
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PALETTE_COUNT: count_model           = data;
            REG_RED_WEIGHT:    weight_model[CH_RED]   = data[WEIGHT_W-1:0];
            REG_GREEN_WEIGHT:  weight_model[CH_GREEN] = data[WEIGHT_W-1:0];
            REG_BLUE_WEIGHT:   weight_model[CH_BLUE]  = data[WEIGHT_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all four registers; the unused top bit of a weight write is random.
    task automatic configure(logic [PCOUNT_W-1:0] count, logic [WEIGHT_W-1:0] rw,
                             logic [WEIGHT_W-1:0] gw, logic [WEIGHT_W-1:0] bw);
        set_register(REG_PALETTE_COUNT, count);
        set_register(REG_RED_WEIGHT,   {1'($urandom_range(0, 1)), rw});
        set_register(REG_GREEN_WEIGHT, {1'($urandom_range(0, 1)), gw});
        set_register(REG_BLUE_WEIGHT,  {1'($urandom_range(0, 1)), bw});
    endtask

    // Sends one request word and updates the shadow state when it is accepted.
    task automatic send_request(logic func, logic [INDEX_W-1:0] slot, logic [ENTRY_W-1:0] color);
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.func        <= func;
        req_bus.entry_index <= slot;
        req_bus.red         <= color[23:16];
        req_bus.green       <= color[15:8];
        req_bus.blue        <= color[7:0];
        do
            @(posedge clk);
        while (!req_bus.ready);
        if (func == FUNC_WRITE)
            palette_model[slot] = color;
        else
            pending_matches.push_back(nearest_entry(color));
    endtask

    // Stops sending and waits until every search result is back and the core is quiet.
    task automatic finish_phase();
        req_bus.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Empty palette straight out of reset, with the reset weights.
    task automatic test_empty_palette();
        send_request(FUNC_QUERY, 8'h00, 24'h000000);
        send_request(FUNC_QUERY, 8'hFF, 24'hFFFFFF);
        finish_phase();
    endtask

    // Corner colors, ties, exact matches, zero and full weights.
    task automatic test_directed_palette();
        send_request(FUNC_WRITE, 8'd0, 24'hFFFFFF);
        send_request(FUNC_WRITE, 8'd1, 24'h000000);
        send_request(FUNC_WRITE, 8'd2, 24'hFF0000);
        send_request(FUNC_WRITE, 8'd3, 24'h00FF00);
        send_request(FUNC_WRITE, 8'd4, 24'h0000FF);
        send_request(FUNC_WRITE, 8'd5, 24'h808080);
        send_request(FUNC_WRITE, 8'd6, 24'hFF0000);
        send_request(FUNC_WRITE, 8'd7, 24'h7F7F7F);
        finish_phase();

        // Largest possible distance: white entry, black query, full weights.
        configure(9'd1, 8'hFF, 8'hFF, 8'hFF);
        send_request(FUNC_QUERY, 8'h00, 24'h000000);
        finish_phase();

        // Tie between two copies of red, early exits at the first and the last entry.
        configure(9'd8, 8'd1, 8'd1, 8'd1);
        send_request(FUNC_QUERY, 8'h55, 24'hFE0101);
        send_request(FUNC_QUERY, 8'hAA, 24'h00FF00);
        send_request(FUNC_QUERY, 8'h00, 24'hFFFFFF);
        send_request(FUNC_QUERY, 8'hFF, 24'h7F7F7F);
        finish_phase();

        // With every weight at zero all entries tie at zero.
        configure(9'd8, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_QUERY, 8'h12, 24'h123456);
        finish_phase();

        // Only red counts.
        configure(9'd8, 8'hFF, 8'd0, 8'd0);
        send_request(FUNC_QUERY, 8'h34, 24'hFF00FF);
        finish_phase();

        // Palette count written back to zero.
        configure(9'd0, 8'd1, 8'd1, 8'd1);
        send_request(FUNC_QUERY, 8'h56, 24'hFFFFFF);
        finish_phase();
    endtask

    // Fills the rest of the palette, then searches it whole and with counts past its depth.
    task automatic test_full_palette();
        for (int s = 8; s < PALETTE_DEPTH; s++)
            send_request(FUNC_WRITE, INDEX_W'(s), ENTRY_W'($urandom));
        finish_phase();

        configure(PCOUNT_W'(PALETTE_DEPTH), random_weight(), random_weight(), random_weight());
        send_request(FUNC_QUERY, INDEX_W'($urandom), ENTRY_W'($urandom));
        send_request(FUNC_QUERY, INDEX_W'($urandom), palette_model[PALETTE_DEPTH-1]);
        finish_phase();

        // Counts above the depth search the whole palette.
        configure(PCOUNT_W'(PALETTE_DEPTH + 1), 8'd1, 8'd1, 8'd1);
        send_request(FUNC_QUERY, INDEX_W'($urandom), ENTRY_W'($urandom));
        finish_phase();
        configure(9'h1FF, random_weight(), random_weight(), random_weight());
        send_request(FUNC_QUERY, INDEX_W'($urandom), palette_model[PALETTE_DEPTH-1]);
        finish_phase();
    endtask

    // Phases of random settings, each with a mix of palette writes and searches.
    task automatic test_random_searches();
        int                  words;
        int                  pick;
        int                  searched;
        int                  phase_len;
        logic [PCOUNT_W-1:0] count;
        logic [ENTRY_W-1:0]  color;
        words = 0;
        while (words < RANDOM_WORDS)
        begin
            // The closing phases run without any idling.
            quiet_mode = (words >= RANDOM_WORDS - 70);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                count = '0;
            else if (pick < 65)
                count = PCOUNT_W'($urandom_range(1, 16));
            else if (pick < 80)
                count = PCOUNT_W'($urandom_range(17, 64));
            else if (pick < 93)
                count = PCOUNT_W'($urandom_range(200, PALETTE_DEPTH));
            else
                count = PCOUNT_W'($urandom_range(PALETTE_DEPTH + 1, 511));
            configure(count, random_weight(), random_weight(), random_weight());
            searched  = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
            // Long searches are slow, so those phases stay short.
            phase_len = (searched > 64) ? 6 : 30;
            repeat (phase_len)
            begin
                color = ENTRY_W'($urandom);
                if ($urandom_range(0, 99) < 35)
                    send_request(FUNC_WRITE, INDEX_W'($urandom), color);
                else
                begin
                    // Half of the searches aim at a stored color, some of them off by one bit.
                    if (searched > 0 && $urandom_range(0, 1) == 1)
                    begin
                        color = palette_model[$urandom_range(0, searched - 1)];
                        if ($urandom_range(0, 3) == 0)
                            color ^= ENTRY_W'(1) << $urandom_range(0, ENTRY_W - 1);
                    end
                    send_request(FUNC_QUERY, INDEX_W'($urandom), color);
                end
                words++;
            end
            finish_phase();
        end
    endtask

    // Counts a failure and reports the first few.
    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
            note_failure($sformatf("%s expected %0d, got %0d", name, exp_val, act_val));
    endtask

    // Result checker: each accepted word against the oldest expected match.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_matches.size() == 0)
                note_failure("result word with no search pending");
            else
            begin
                expected_match = pending_matches.pop_front();
                check_field("match_index", expected_match.index, rsp_bus.match_index);
                check_field("match_found", expected_match.found, rsp_bus.match_found);
                check_field("match_distance", expected_match.distance,
                            rsp_bus.match_distance);
            end
        end
    end

    // Result side back-pressure in bursts; the burst rate changes every window.
    initial
    begin
        rsp_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall_window--;
            if (stall_window == 0)
            begin
                stall_window = 64;
                case ($urandom_range(0, 2))
                    0:       rsp_stall_pct = 0;
                    1:       rsp_stall_pct = 10;
                    default: rsp_stall_pct = 40;
                endcase
            end
            if (!quiet_mode && $urandom_range(0, 99) < rsp_stall_pct)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Hang detection: cycles in which no word and no register write is accepted.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.func        <= FUNC_WRITE;
        req_bus.entry_index <= '0;
        req_bus.red         <= '0;
        req_bus.green       <= '0;
        req_bus.blue        <= '0;
        count_model            = '0;
        weight_model[CH_RED]   = 8'd1;
        weight_model[CH_GREEN] = 8'd1;
        weight_model[CH_BLUE]  = 8'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_palette();
        test_directed_palette();
        test_full_palette();
        test_random_searches();

        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
